### rtl/i2cm_pkg.sv
// Shared types and constants of the I2C master bit engine.
// No dependencies; every other file of the block imports this package.
package i2cm_pkg;

    localparam int QD_W      = 8;   // quarter_delay register width
    localparam int SL_W      = 20;  // stretch_limit register width
    localparam int WAIT_W    = 9;   // wait counter, holds quarter_delay + 2
    localparam int BIT_W     = 4;   // bit counter, holds 0 to 8
    localparam int BYTE_W    = 8;
    localparam int PHASE_W   = 4;
    localparam int CFG_IDX_W = 1;

    localparam int STRETCH_BASE = 230;
    localparam int STRETCH_MULT = 3;

    localparam logic [QD_W-1:0]  QD_RESET = QD_W'(1);
    localparam logic [SL_W-1:0]  SL_RESET = SL_W'(STRETCH_BASE * STRETCH_MULT);
    localparam logic [BIT_W-1:0] BITS_PER_BYTE = BIT_W'(BYTE_W);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_QUARTER_DELAY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRETCH_LIMIT = 1'b1;

    // Command opcodes.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Sequencer phases.
    localparam logic [PHASE_W-1:0] PH_IDLE         = 4'd0;
    localparam logic [PHASE_W-1:0] PH_START_CHECK  = 4'd1;
    localparam logic [PHASE_W-1:0] PH_START_W1     = 4'd2;
    localparam logic [PHASE_W-1:0] PH_START_W2     = 4'd3;
    localparam logic [PHASE_W-1:0] PH_STOP_W1      = 4'd4;
    localparam logic [PHASE_W-1:0] PH_STOP_STRETCH = 4'd5;
    localparam logic [PHASE_W-1:0] PH_STOP_W2      = 4'd6;
    localparam logic [PHASE_W-1:0] PH_STOP_W3      = 4'd7;
    localparam logic [PHASE_W-1:0] PH_WR_SETUP     = 4'd8;
    localparam logic [PHASE_W-1:0] PH_WR_STRETCH   = 4'd9;
    localparam logic [PHASE_W-1:0] PH_WR_HOLD      = 4'd10;
    localparam logic [PHASE_W-1:0] PH_RD_SETUP     = 4'd11;
    localparam logic [PHASE_W-1:0] PH_RD_STRETCH   = 4'd12;
    localparam logic [PHASE_W-1:0] PH_RD_HOLD      = 4'd13;

    // One tick: optional command plus sampled line levels.
    typedef struct packed {
        logic              cmd_valid;
        logic [1:0]        opcode;
        logic [BYTE_W-1:0] tx_byte;
        logic              send_nack;
        logic              scl_in;
        logic              sda_in;
    } in_item_t;

    // Line drives and status after one tick.
    typedef struct packed {
        logic              scl_drive_low;
        logic              sda_drive_low;
        logic              ready_res;
        logic              done_res;
        logic              ack_ok;
        logic [BYTE_W-1:0] rx_byte;
        logic              status;
    } res_t;

endpackage

### rtl/i2cm_in_stage.sv
// Input register of the I2C master bit engine, with its stall logic.
// Depends on i2cm_pkg for the item type.
module i2cm_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  i2cm_pkg::in_item_t in_item,
    input  logic              downstream_free,
    output logic              step_en,
    output i2cm_pkg::in_item_t item
);
    import i2cm_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     accept;

    // The held item moves on whenever the result register can take a result.
    assign step_en  = valid_reg && downstream_free;
    assign in_stall = valid_reg && !downstream_free;
    assign accept   = in_valid && !in_stall;
    assign item     = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (step_en)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

endmodule

### rtl/i2cm_out_stage.sv
// Result register of the I2C master bit engine.
// Depends on i2cm_pkg for the result type.
module i2cm_out_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  i2cm_pkg::res_t  res_in,
    output logic            free,
    output logic            out_valid,
    input  logic            out_stall,
    output i2cm_pkg::res_t  res_out
);
    import i2cm_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    // Free when empty or when the held result leaves at this edge.
    assign free      = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign res_out   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

endmodule

### rtl/i2cm_core.sv
// Bus sequencer of the I2C master bit engine: configuration, state and one tick of work.
// Depends on i2cm_pkg for phases, opcodes, widths and the item and result types.
module i2cm_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [i2cm_pkg::SL_W-1:0]       cfg_data,
    input  logic                            step_en,
    input  i2cm_pkg::in_item_t              item,
    output i2cm_pkg::res_t                  res
);
    import i2cm_pkg::*;

    typedef struct packed {
        logic              sda_low;
        logic [WAIT_W-1:0] wait_cnt;
    } bit_setup_t;

    logic [QD_W-1:0]    quarter_delay_reg;
    logic [SL_W-1:0]    stretch_limit_reg;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [BIT_W-1:0]   bit_index_reg, bit_index_next;
    logic [BYTE_W-1:0]  shift_reg, shift_next;
    logic [WAIT_W-1:0]  wait_count_reg, wait_count_next;
    logic [SL_W-1:0]    stretch_count_reg, stretch_count_next;
    logic               scl_low_reg, scl_low_next;
    logic               sda_low_reg, sda_low_next;
    logic               ack_reg, ack_next;
    logic               nack_reg, nack_next;
    logic [BYTE_W-1:0]  rx_last_reg, rx_last_next;
    logic               done_c;
    logic               status_c;
    logic               waiting;
    logic               stretched;
    bit_setup_t         setup;

    // Drive for the next bit: a read bit releases SDA and waits two extra
    // ticks, a written bit drives its data and waits one extra tick.
    function automatic bit_setup_t begin_bit(
        input logic              rd_group,
        input logic [BIT_W-1:0]  bi,
        input logic              msb,
        input logic              nack,
        input logic [QD_W-1:0]   qd
    );
        bit_setup_t r;
        logic       rd;
        logic       v;
        rd = rd_group != (bi >= BITS_PER_BYTE);
        v  = rd_group ? nack : msb;
        if (rd)
        begin
            r.sda_low  = 1'b0;
            r.wait_cnt = WAIT_W'(qd) + WAIT_W'(2);
        end
        else
        begin
            r.sda_low  = !v;
            r.wait_cnt = WAIT_W'(qd) + WAIT_W'(1);
        end
        return r;
    endfunction

    assign waiting = (wait_count_reg != '0) && (phase_reg != PH_IDLE)
                  && (phase_reg != PH_START_CHECK) && (phase_reg != PH_STOP_STRETCH)
                  && (phase_reg != PH_WR_STRETCH) && (phase_reg != PH_RD_STRETCH);

    assign stretched = !item.scl_in && (stretch_count_reg < stretch_limit_reg);

    always_comb
    begin
        phase_next         = phase_reg;
        bit_index_next     = bit_index_reg;
        shift_next         = shift_reg;
        wait_count_next    = wait_count_reg;
        stretch_count_next = stretch_count_reg;
        scl_low_next       = scl_low_reg;
        sda_low_next       = sda_low_reg;
        ack_next           = ack_reg;
        nack_next          = nack_reg;
        rx_last_next       = rx_last_reg;
        done_c             = 1'b0;
        status_c           = 1'b0;
        setup              = '0;

        if (waiting)
        begin
            wait_count_next = wait_count_reg - WAIT_W'(1);
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (item.cmd_valid)
                    begin
                        if (item.opcode == OP_START)
                        begin
                            scl_low_next = 1'b0;
                            sda_low_next = 1'b0;
                            phase_next   = PH_START_CHECK;
                        end
                        else if (item.opcode == OP_STOP)
                        begin
                            scl_low_next    = 1'b1;
                            sda_low_next    = 1'b1;
                            wait_count_next = WAIT_W'(quarter_delay_reg);
                            phase_next      = PH_STOP_W1;
                        end
                        else
                        begin
                            bit_index_next  = '0;
                            shift_next      = (item.opcode == OP_WRITE) ? item.tx_byte : '0;
                            nack_next       = item.send_nack;
                            phase_next      = (item.opcode == OP_WRITE) ? PH_WR_SETUP
                                                                        : PH_RD_SETUP;
                            setup           = begin_bit(item.opcode == OP_READ, '0,
                                                        item.tx_byte[BYTE_W-1],
                                                        item.send_nack, quarter_delay_reg);
                            scl_low_next    = 1'b1;
                            sda_low_next    = setup.sda_low;
                            wait_count_next = setup.wait_cnt;
                        end
                    end
                end
                PH_START_CHECK:
                begin
                    if (!item.sda_in)
                    begin
                        done_c     = 1'b1;
                        status_c   = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        wait_count_next = WAIT_W'(quarter_delay_reg);
                        phase_next      = PH_START_W1;
                    end
                end
                PH_START_W1:
                begin
                    sda_low_next    = 1'b1;
                    wait_count_next = WAIT_W'(quarter_delay_reg);
                    phase_next      = PH_START_W2;
                end
                PH_START_W2, PH_STOP_W3:
                begin
                    done_c     = 1'b1;
                    phase_next = PH_IDLE;
                end
                PH_STOP_W1:
                begin
                    scl_low_next       = 1'b0;
                    stretch_count_next = '0;
                    phase_next         = PH_STOP_STRETCH;
                end
                PH_STOP_STRETCH:
                begin
                    if (stretched)
                    begin
                        stretch_count_next = stretch_count_reg + SL_W'(1);
                    end
                    else
                    begin
                        wait_count_next = WAIT_W'(quarter_delay_reg);
                        phase_next      = PH_STOP_W2;
                    end
                end
                PH_STOP_W2:
                begin
                    sda_low_next    = 1'b0;
                    wait_count_next = WAIT_W'(quarter_delay_reg);
                    phase_next      = PH_STOP_W3;
                end
                PH_WR_SETUP, PH_RD_SETUP:
                begin
                    scl_low_next       = 1'b0;
                    stretch_count_next = '0;
                    phase_next         = (phase_reg == PH_WR_SETUP) ? PH_WR_STRETCH
                                                                    : PH_RD_STRETCH;
                end
                PH_WR_STRETCH, PH_RD_STRETCH:
                begin
                    if (stretched)
                    begin
                        stretch_count_next = stretch_count_reg + SL_W'(1);
                    end
                    else
                    begin
                        if (phase_reg == PH_RD_STRETCH)
                        begin
                            if (bit_index_reg < BITS_PER_BYTE)
                            begin
                                shift_next = {shift_reg[BYTE_W-2:0], item.sda_in};
                            end
                            phase_next = PH_RD_HOLD;
                        end
                        else
                        begin
                            if (bit_index_reg < BITS_PER_BYTE)
                            begin
                                shift_next = {shift_reg[BYTE_W-2:0], 1'b0};
                            end
                            else
                            begin
                                ack_next = !item.sda_in;
                            end
                            phase_next = PH_WR_HOLD;
                        end
                        wait_count_next = WAIT_W'(quarter_delay_reg);
                    end
                end
                PH_WR_HOLD, PH_RD_HOLD:
                begin
                    if (bit_index_reg >= BITS_PER_BYTE)
                    begin
                        if (phase_reg == PH_RD_HOLD)
                        begin
                            rx_last_next = shift_reg;
                        end
                        bit_index_next = '0;
                        done_c         = 1'b1;
                        phase_next     = PH_IDLE;
                    end
                    else
                    begin
                        bit_index_next  = bit_index_reg + BIT_W'(1);
                        phase_next      = (phase_reg == PH_WR_HOLD) ? PH_WR_SETUP
                                                                    : PH_RD_SETUP;
                        setup           = begin_bit(phase_reg == PH_RD_HOLD,
                                                    bit_index_reg + BIT_W'(1),
                                                    shift_reg[BYTE_W-1], nack_reg,
                                                    quarter_delay_reg);
                        scl_low_next    = 1'b1;
                        sda_low_next    = setup.sda_low;
                        wait_count_next = setup.wait_cnt;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    assign res.scl_drive_low = scl_low_next;
    assign res.sda_drive_low = sda_low_next;
    assign res.ready_res     = (phase_next == PH_IDLE);
    assign res.done_res      = done_c;
    assign res.ack_ok        = ack_next;
    assign res.rx_byte       = rx_last_next;
    assign res.status        = status_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quarter_delay_reg <= QD_RESET;
            stretch_limit_reg <= SL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_QUARTER_DELAY: quarter_delay_reg <= cfg_data[QD_W-1:0];
                CFG_STRETCH_LIMIT: stretch_limit_reg <= cfg_data;
                default:           quarter_delay_reg <= quarter_delay_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            bit_index_reg     <= '0;
            shift_reg         <= '0;
            wait_count_reg    <= '0;
            stretch_count_reg <= '0;
            scl_low_reg       <= 1'b0;
            sda_low_reg       <= 1'b0;
            ack_reg           <= 1'b0;
            nack_reg          <= 1'b0;
            rx_last_reg       <= '0;
        end
        else if (step_en)
        begin
            phase_reg         <= phase_next;
            bit_index_reg     <= bit_index_next;
            shift_reg         <= shift_next;
            wait_count_reg    <= wait_count_next;
            stretch_count_reg <= stretch_count_next;
            scl_low_reg       <= scl_low_next;
            sda_low_reg       <= sda_low_next;
            ack_reg           <= ack_next;
            nack_reg          <= nack_next;
            rx_last_reg       <= rx_last_next;
        end
    end

`ifndef SYNTH
    // A completed command always leaves the sequencer idle.
    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && done_c |=> phase_reg == PH_IDLE)
        else $error("sequencer not idle after a completed command");

    // A refused start is only ever reported on a completion tick.
    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && status_c |-> done_c && phase_reg == PH_START_CHECK)
        else $error("start refusal outside the start check");

    // The bit counter never runs past the acknowledge bit.
    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_index_reg <= BITS_PER_BYTE)
        else $error("bit counter out of range");

    // With no tick offered, the sequencer state holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> $stable(phase_reg) && $stable(wait_count_reg))
        else $error("sequencer moved without a tick");
`endif

endmodule

### rtl/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: input register, sequencer, result register.
// Depends on i2cm_pkg, i2cm_in_stage, i2cm_core and i2cm_out_stage.
//
// Usage: every input item is one tick of the bus timing base. It carries the
// sampled SCL and SDA levels and, when cmd_valid is set, a command (start,
// stop, write byte or read byte). Each accepted item yields exactly one result
// item holding the open-drain drives for SCL and SDA, the ready flag, the
// done pulse, the held ACK of the last write, the last read byte and the
// start-refused status. Commands offered while the sequencer is busy are
// ignored, so the host should offer one only while ready_res is high.
// Both channels use valid and stall; an item moves on an edge where valid is
// high and stall is low. The input register holds the accepted item, and the
// sequencer logic then loads its result into the result register once that
// register is free. Throughput is one item per cycle while the receiver does
// not stall; the sequencer state updates once per tick.
// When the receiver stalls, the result register holds its item, the input
// register still fills once, and only then is in_stall raised.
// Reset (rst_n low, asynchronous) empties both registers, returns the sequencer to idle
// with SCL and SDA drives released (result data is not reset) and loads quarter_delay
// with 1 and stretch_limit with 690. Configuration writes take effect at once.
module i2c_master_bit_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [i2cm_pkg::SL_W-1:0]       cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            cmd_valid,
    input  logic [1:0]                      opcode,
    input  logic [i2cm_pkg::BYTE_W-1:0]     tx_byte,
    input  logic                            send_nack,
    input  logic                            scl_in,
    input  logic                            sda_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            scl_drive_low,
    output logic                            sda_drive_low,
    output logic                            ready_res,
    output logic                            done_res,
    output logic                            ack_ok,
    output logic [i2cm_pkg::BYTE_W-1:0]     rx_byte,
    output logic                            status
);
    import i2cm_pkg::*;

    in_item_t in_item;
    in_item_t item;
    res_t     res_c;
    res_t     res_q;
    logic     step_en;
    logic     out_free;

    assign in_item.cmd_valid = cmd_valid;
    assign in_item.opcode    = opcode;
    assign in_item.tx_byte   = tx_byte;
    assign in_item.send_nack = send_nack;
    assign in_item.scl_in    = scl_in;
    assign in_item.sda_in    = sda_in;

    i2cm_in_stage u_in_stage (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_item         (in_item),
        .downstream_free (out_free),
        .step_en         (step_en),
        .item            (item)
    );

    i2cm_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step_en   (step_en),
        .item      (item),
        .res       (res_c)
    );

    i2cm_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step_en),
        .res_in    (res_c),
        .free      (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_out   (res_q)
    );

    assign scl_drive_low = res_q.scl_drive_low;
    assign sda_drive_low = res_q.sda_drive_low;
    assign ready_res     = res_q.ready_res;
    assign done_res      = res_q.done_res;
    assign ack_ok        = res_q.ack_ok;
    assign rx_byte       = res_q.rx_byte;
    assign status        = res_q.status;

`ifndef SYNTH
    // The input side is only stalled while a result waits on a stalled output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with the output free");

    // Every tick processed shows up as a valid result on the next cycle.
    a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> out_valid)
        else $error("processed tick produced no result");

    // A start refusal is always reported together with its done pulse.
    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> done_res && ready_res)
        else $error("status without completion");
`endif

endmodule
